@@ sv/csp_pkg.sv @@
// Shared types, widths and operation codes for the segment push-out block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package csp_pkg;

   localparam int COORD_W         = 20;            // signed Q11.8 coordinate
   localparam int DIFF_W          = COORD_W + 1;   // difference of two coordinates
   localparam int SQ_W            = 2 * DIFF_W;    // sum of two squared differences
   localparam int QUO_W           = DIFF_W + 1;    // divider / root result
   localparam int ACC_W           = 64;            // multiply accumulator
   localparam int MUL_W           = 24;            // multiplier operand
   localparam int PROD_W          = 2 * MUL_W;
   localparam int UPD_W           = 24;            // position update before saturation
   localparam int RAD_W           = 16;            // Q8.8 radius
   localparam int MRG_W           = RAD_W + 1;     // sum of two radii
   localparam int CNT_CFG_W       = 5;
   localparam int IDX_IN_W        = 4;
   localparam int MAX_COLLIDERS_D = 16;
   localparam int NEAR_ZERO       = 6;             // 0.0001 in Q.16
   localparam int PLAYER_R_RESET  = 128;

   typedef logic [5:0] op_type;

   localparam op_type OP_IDLE  = 6'd0;
   localparam op_type OP_WRITE = 6'd1;
   localparam op_type OP_START = 6'd2;
   localparam op_type OP_AB    = 6'd3;
   localparam op_type OP_L0    = 6'd4;
   localparam op_type OP_L1    = 6'd5;
   localparam op_type OP_D0    = 6'd6;
   localparam op_type OP_D1    = 6'd7;
   localparam op_type OP_CLAMP = 6'd8;
   localparam op_type OP_N0X   = 6'd9;
   localparam op_type OP_N1X   = 6'd10;
   localparam op_type OP_DIVX  = 6'd11;
   localparam op_type OP_CX    = 6'd12;
   localparam op_type OP_N0Z   = 6'd13;
   localparam op_type OP_N1Z   = 6'd14;
   localparam op_type OP_DIVZ  = 6'd15;
   localparam op_type OP_CZ    = 6'd16;
   localparam op_type OP_DL    = 6'd17;
   localparam op_type OP_E0    = 6'd18;
   localparam op_type OP_E1    = 6'd19;
   localparam op_type OP_MS    = 6'd20;
   localparam op_type OP_MM    = 6'd21;
   localparam op_type OP_SQRT  = 6'd22;
   localparam op_type OP_PUSH  = 6'd23;
   localparam op_type OP_P0X   = 6'd24;
   localparam op_type OP_DIVPX = 6'd25;
   localparam op_type OP_PX    = 6'd26;
   localparam op_type OP_P0Z   = 6'd27;
   localparam op_type OP_DIVPZ = 6'd28;
   localparam op_type OP_PZ    = 6'd29;
   localparam op_type OP_NEAR  = 6'd30;
   localparam op_type OP_NEXT  = 6'd31;
   localparam op_type OP_OUT   = 6'd32;

   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_RESOLVE = 1'b1;

   localparam logic CSR_COUNT  = 1'b0;
   localparam logic CSR_RADIUS = 1'b1;

   typedef struct packed {
      logic                       kind;
      logic [IDX_IN_W-1:0]        entry_index;
      logic signed [COORD_W-1:0]  end_a_x;
      logic signed [COORD_W-1:0]  end_a_z;
      logic signed [COORD_W-1:0]  end_b_x;
      logic signed [COORD_W-1:0]  end_b_z;
      logic [RAD_W-1:0]           capsule_radius;
      logic signed [COORD_W-1:0]  player_x;
      logic signed [COORD_W-1:0]  player_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_z;
      logic                      moved;
   } rsp_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last;
      logic long_seg;
      logic contact;
      logic near;
      logic div_busy;
      logic sqrt_busy;
      logic out_busy;
   } stat_type;

endpackage

@@ sv/circle_segment_push_out_unit.sv @@
// Top level of the circle versus capsule push-out block: register port and wiring.
// Depends on csp_pkg, csp_ctrl and csp_dpath.
`timescale 1ns / 1ps

// Holds up to MAX_COLLIDERS capsule colliders (two segment ends in signed Q11.8
// and an unsigned Q8.8 radius). A write request (kind 0) loads one table slot and
// returns nothing; slots at or beyond MAX_COLLIDERS are
// dropped. A resolve request (kind 1) carries a player position, visits slots
// 0 .. collider_count-1 in order (count clamped to MAX_COLLIDERS), pushes the
// player out of every overlapping collider and returns one response with the
// saturated position and a moved flag. Only slots already written may be
// visited. One request is worked at a time; req_stall is high while a resolve
// runs. Per collider the slot is read and tested for contact; a segment of real
// length adds two divides for the closest point on it, each waiting on the
// 22-step divider, and a push adds the 21-step root and then two more divides.
// A contact with squared center distance at most NEAR_ZERO takes the near step
// instead of the root and its divides. The iterative divider, shared by all
// four divides, sets most of the run time.
// A finished response sits in an output register, so a new request may start
// while the last response is still stalled; it only waits at its own end.
// Registers (APB, 4-byte stride): 0x0 collider_count (5 bits, reset 0),
// 0x4 player_radius (16 bits, reset 128). Write them only while idle.

module circle_segment_push_out_unit #(
   parameter int MAX_COLLIDERS = csp_pkg::MAX_COLLIDERS_D
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  csp_pkg::req_type  req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csp_pkg::rsp_type  rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [csp_pkg::CNT_CFG_W-1:0] count_ff;
   logic [csp_pkg::RAD_W-1:0]     radius_ff;
   logic                          csr_wr_in;
   csp_pkg::cmd_type              cmd;
   csp_pkg::stat_type             stat;

   // register writes land on the access phase; paddr[2] picks the register
   assign csr_wr_in = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         radius_ff <= csp_pkg::RAD_W'(csp_pkg::PLAYER_R_RESET);
      end else if (csr_wr_in) begin
         case (paddr[2])
            csp_pkg::CSR_COUNT:  count_ff  <= pwdata[csp_pkg::CNT_CFG_W-1:0];
            csp_pkg::CSR_RADIUS: radius_ff <= pwdata[csp_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         csp_pkg::CSR_COUNT:  prdata = 32'(count_ff);
         csp_pkg::CSR_RADIUS: prdata = 32'(radius_ff);
         default:             prdata = '0;
      endcase
   end

   // sequencer: at most one op per cycle, waits on divider/root busy and a stalled response
   csp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // table, working registers, multiplier, divider, root, response register
   csp_dpath #(
      .MAX_COLLIDERS (MAX_COLLIDERS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .cfg_count  (count_ff),
      .cfg_radius (radius_ff),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

@@ sv/csp_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [csp_pkg::ACC_W-1:0]      num,
   input  logic [csp_pkg::SQ_W-1:0]       den,
   output logic                           busy,
   output logic [csp_pkg::QUO_W-1:0]      quo
);

   localparam int QW = csp_pkg::QUO_W;
   localparam int DW = csp_pkg::SQ_W;

   logic [DW-1:0]          rem_ff;
   logic [DW-1:0]          den_ff;
   logic [QW-1:0]          lo_ff;
   logic [QW-1:0]          quo_ff;
   logic [$clog2(QW+1)-1:0] cnt_ff;
   logic                   busy_ff;
   logic [DW:0]            trial_in;
   logic                   take_in;

   assign trial_in = {rem_ff, lo_ff[QW-1]};
   assign take_in  = trial_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= ($clog2(QW+1))'(QW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= cnt_ff != 1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num[csp_pkg::ACC_W-1:QW];
         lo_ff  <= num[QW-1:0];
         den_ff <= den;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= take_in ? DW'(trial_in - {1'b0, den_ff}) : trial_in[DW-1:0];
         lo_ff  <= {lo_ff[QW-2:0], 1'b0};
         quo_ff <= {quo_ff[QW-2:0], take_in};
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

@@ sv/csp_sqrt.sv @@
// Bit-pair square root, one result bit per cycle, rounded to nearest at the end.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [csp_pkg::SQ_W-1:0]   val,
   output logic                       busy,
   output logic [csp_pkg::QUO_W-1:0]  root
);

   localparam int SW = csp_pkg::SQ_W;

   logic [SW-1:0] x_ff;
   logic [SW-1:0] r_ff;
   logic [SW-1:0] bit_ff;
   logic          busy_ff;
   logic [SW-1:0] t_in;

   assign t_in = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         busy_ff <= (bit_ff >> 2) != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= val;
         r_ff   <= '0;
         bit_ff <= SW'(1) << (SW - 2);
      end else if (busy_ff) begin
         if (x_ff >= t_in) begin
            x_ff <= x_ff - t_in;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // round up when the remainder exceeds the root
   assign root = r_ff[csp_pkg::QUO_W-1:0] + csp_pkg::QUO_W'(x_ff > r_ff);
   assign busy = busy_ff;

endmodule

@@ sv/csp_dpath.sv @@
// Datapath: collider table, working registers, shared multiplier, divider and root.
// Depends on csp_pkg, csp_div and csp_sqrt.
`timescale 1ns / 1ps

module csp_dpath #(
   parameter int MAX_COLLIDERS = csp_pkg::MAX_COLLIDERS_D
) (
   input  logic                              clock,
   input  logic                              reset,
   input  csp_pkg::cmd_type                  cmd,
   input  csp_pkg::req_type                  req_data,
   input  logic [csp_pkg::CNT_CFG_W-1:0]     cfg_count,
   input  logic [csp_pkg::RAD_W-1:0]         cfg_radius,
   input  logic                              rsp_stall,
   output csp_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   output csp_pkg::rsp_type                  rsp_data
);

   localparam int CW   = csp_pkg::COORD_W;
   localparam int DW   = csp_pkg::DIFF_W;
   localparam int SW   = csp_pkg::SQ_W;
   localparam int QW   = csp_pkg::QUO_W;
   localparam int AW   = csp_pkg::ACC_W;
   localparam int MW   = csp_pkg::MUL_W;
   localparam int PW   = csp_pkg::PROD_W;
   localparam int UW   = csp_pkg::UPD_W;
   localparam int RW   = csp_pkg::RAD_W;
   localparam int GW   = csp_pkg::MRG_W;
   localparam int IW   = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
   localparam int CNTW = $clog2(MAX_COLLIDERS + 1);

   // collider table
   logic signed [CW-1:0] mem_ax [MAX_COLLIDERS];
   logic signed [CW-1:0] mem_az [MAX_COLLIDERS];
   logic signed [CW-1:0] mem_bx [MAX_COLLIDERS];
   logic signed [CW-1:0] mem_bz [MAX_COLLIDERS];
   logic [RW-1:0]        mem_r  [MAX_COLLIDERS];

   logic signed [CW-1:0] rd_ax_ff, rd_az_ff, rd_bx_ff, rd_bz_ff;
   logic [RW-1:0]        rd_r_ff;

   logic [CNTW-1:0]      idx_ff;
   logic signed [CW-1:0] px_ff, pz_ff, cx_ff, cz_ff;
   logic                 moved_ff;
   logic signed [DW-1:0] abx_ff, abz_ff, relx_ff, relz_ff, dx_ff, dz_ff;
   logic [SW-1:0]        len_ff, d_ff, dist2_ff;
   logic [GW-1:0]        m_ff, push_ff;
   logic [QW-1:0]        dist_ff;
   logic signed [AW-1:0] acc_ff;
   csp_pkg::rsp_type     rsp_ff;
   logic                 rsp_valid_ff;

   logic [8:0]           widx_in;
   logic [8:0]           cnt_sat_in;
   logic [CNTW-1:0]      count_in;
   logic [DW-1:0]        absx_in, absz_in, absdx_in, absdz_in;
   logic signed [MW-1:0] ma_in, mb_in;
   logic signed [PW-1:0] prod_in;
   logic signed [AW-1:0] prod_ext_in;
   logic signed [AW-1:0] acc_in;
   logic                 div_start_in, div_busy;
   logic [AW-1:0]        div_num_in;
   logic [SW-1:0]        div_den_in;
   logic [QW-1:0]        quo;
   logic                 sqrt_busy;
   logic [QW-1:0]        root;
   logic signed [UW-1:0] q_pos_in, q_x_in, q_z_in;

   function automatic logic signed [CW-1:0] sat(input logic signed [UW-1:0] v);
      logic signed [UW-1:0] hi;
      logic signed [UW-1:0] lo;
      hi = UW'((2 ** (CW - 1)) - 1);
      lo = -hi - UW'(1);
      if (v > hi) begin
         sat = hi[CW-1:0];
      end else if (v < lo) begin
         sat = lo[CW-1:0];
      end else begin
         sat = v[CW-1:0];
      end
   endfunction

   assign widx_in    = {5'b0, req_data.entry_index};
   assign cnt_sat_in = ({4'b0, cfg_count} > 9'(MAX_COLLIDERS)) ? 9'(MAX_COLLIDERS)
                                                              : {4'b0, cfg_count};
   assign count_in   = cnt_sat_in[CNTW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.op == csp_pkg::OP_WRITE && widx_in < 9'(MAX_COLLIDERS)) begin
         mem_ax[widx_in[IW-1:0]] <= req_data.end_a_x;
         mem_az[widx_in[IW-1:0]] <= req_data.end_a_z;
         mem_bx[widx_in[IW-1:0]] <= req_data.end_b_x;
         mem_bz[widx_in[IW-1:0]] <= req_data.end_b_z;
         mem_r[widx_in[IW-1:0]]  <= req_data.capsule_radius;
      end
      rd_ax_ff <= mem_ax[idx_ff[IW-1:0]];
      rd_az_ff <= mem_az[idx_ff[IW-1:0]];
      rd_bx_ff <= mem_bx[idx_ff[IW-1:0]];
      rd_bz_ff <= mem_bz[idx_ff[IW-1:0]];
      rd_r_ff  <= mem_r[idx_ff[IW-1:0]];
   end

   assign absx_in  = abx_ff[DW-1] ? DW'(-abx_ff) : abx_ff;
   assign absz_in  = abz_ff[DW-1] ? DW'(-abz_ff) : abz_ff;
   assign absdx_in = dx_ff[DW-1]  ? DW'(-dx_ff)  : dx_ff;
   assign absdz_in = dz_ff[DW-1]  ? DW'(-dz_ff)  : dz_ff;

   // shared multiplier operand select
   always_comb begin
      ma_in = '0;
      mb_in = '0;
      case (cmd.op)
         csp_pkg::OP_L0: begin ma_in = MW'(abx_ff);  mb_in = MW'(abx_ff); end
         csp_pkg::OP_L1: begin ma_in = MW'(abz_ff);  mb_in = MW'(abz_ff); end
         csp_pkg::OP_D0: begin ma_in = MW'(relx_ff); mb_in = MW'(abx_ff); end
         csp_pkg::OP_D1: begin ma_in = MW'(relz_ff); mb_in = MW'(abz_ff); end
         csp_pkg::OP_N0X: begin
            ma_in = $signed(MW'(absx_in));
            mb_in = $signed(MW'(d_ff[QW-1:0]));
         end
         csp_pkg::OP_N1X: begin
            ma_in = $signed(MW'(absx_in));
            mb_in = $signed(MW'(d_ff[SW-1:QW]));
         end
         csp_pkg::OP_N0Z: begin
            ma_in = $signed(MW'(absz_in));
            mb_in = $signed(MW'(d_ff[QW-1:0]));
         end
         csp_pkg::OP_N1Z: begin
            ma_in = $signed(MW'(absz_in));
            mb_in = $signed(MW'(d_ff[SW-1:QW]));
         end
         csp_pkg::OP_E0: begin ma_in = MW'(dx_ff); mb_in = MW'(dx_ff); end
         csp_pkg::OP_E1: begin ma_in = MW'(dz_ff); mb_in = MW'(dz_ff); end
         csp_pkg::OP_MM: begin
            ma_in = $signed(MW'(m_ff));
            mb_in = $signed(MW'(m_ff));
         end
         csp_pkg::OP_P0X: begin
            ma_in = $signed(MW'(absdx_in));
            mb_in = $signed(MW'(push_ff));
         end
         csp_pkg::OP_P0Z: begin
            ma_in = $signed(MW'(absdz_in));
            mb_in = $signed(MW'(push_ff));
         end
         default: begin
            ma_in = '0;
            mb_in = '0;
         end
      endcase
   end

   assign prod_in     = ma_in * mb_in;
   assign prod_ext_in = AW'(prod_in);

   always_comb begin
      case (cmd.op)
         csp_pkg::OP_L0, csp_pkg::OP_D0, csp_pkg::OP_N0X, csp_pkg::OP_N0Z,
         csp_pkg::OP_E0, csp_pkg::OP_MM, csp_pkg::OP_P0X, csp_pkg::OP_P0Z:
            acc_in = prod_ext_in;
         csp_pkg::OP_L1, csp_pkg::OP_D1, csp_pkg::OP_E1:
            acc_in = acc_ff + prod_ext_in;
         csp_pkg::OP_N1X, csp_pkg::OP_N1Z:
            acc_in = acc_ff + (prod_ext_in <<< QW);
         default:
            acc_in = acc_ff;
      endcase
   end

   // divider feed: rounded numerator is |n| + den/2
   assign div_start_in = cmd.op == csp_pkg::OP_DIVX  || cmd.op == csp_pkg::OP_DIVZ ||
                         cmd.op == csp_pkg::OP_DIVPX || cmd.op == csp_pkg::OP_DIVPZ;
   assign div_den_in   = (cmd.op == csp_pkg::OP_DIVX || cmd.op == csp_pkg::OP_DIVZ)
                         ? len_ff : SW'(dist_ff);
   assign div_num_in   = $unsigned(acc_ff) + AW'(div_den_in >> 1);

   csp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_in),
      .num   (div_num_in),
      .den   (div_den_in),
      .busy  (div_busy),
      .quo   (quo)
   );

   csp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == csp_pkg::OP_SQRT),
      .val   (dist2_ff),
      .busy  (sqrt_busy),
      .root  (root)
   );

   assign q_pos_in = $signed(UW'(quo));
   assign q_x_in   = (cmd.op == csp_pkg::OP_CX ? abx_ff[DW-1] : dx_ff[DW-1])
                     ? -q_pos_in : q_pos_in;
   assign q_z_in   = (cmd.op == csp_pkg::OP_CZ ? abz_ff[DW-1] : dz_ff[DW-1])
                     ? -q_pos_in : q_pos_in;

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (cmd.op)
         csp_pkg::OP_START: begin
            px_ff <= req_data.player_x;
            pz_ff <= req_data.player_z;
         end
         csp_pkg::OP_AB: begin
            abx_ff  <= DW'(rd_bx_ff) - DW'(rd_ax_ff);
            abz_ff  <= DW'(rd_bz_ff) - DW'(rd_az_ff);
            relx_ff <= DW'(px_ff) - DW'(rd_ax_ff);
            relz_ff <= DW'(pz_ff) - DW'(rd_az_ff);
         end
         csp_pkg::OP_D0: len_ff <= acc_ff[SW-1:0];
         csp_pkg::OP_CLAMP: begin
            if (acc_ff < 0) begin
               d_ff <= '0;
            end else if (acc_ff > $signed(AW'(len_ff))) begin
               d_ff <= len_ff;
            end else begin
               d_ff <= acc_ff[SW-1:0];
            end
            cx_ff <= rd_ax_ff;
            cz_ff <= rd_az_ff;
         end
         csp_pkg::OP_CX: cx_ff <= CW'(UW'(rd_ax_ff) + q_x_in);
         csp_pkg::OP_CZ: cz_ff <= CW'(UW'(rd_az_ff) + q_z_in);
         csp_pkg::OP_DL: begin
            dx_ff <= DW'(px_ff) - DW'(cx_ff);
            dz_ff <= DW'(pz_ff) - DW'(cz_ff);
         end
         csp_pkg::OP_MS: begin
            dist2_ff <= acc_ff[SW-1:0];
            m_ff     <= GW'(cfg_radius) + GW'(rd_r_ff);
         end
         csp_pkg::OP_PUSH: begin
            dist_ff <= root;
            push_ff <= m_ff - GW'(root);
         end
         csp_pkg::OP_PX:   px_ff <= sat(UW'(px_ff) + q_x_in);
         csp_pkg::OP_PZ:   pz_ff <= sat(UW'(pz_ff) + q_z_in);
         csp_pkg::OP_NEAR: pz_ff <= sat(UW'(pz_ff) + $signed(UW'(m_ff)));
         csp_pkg::OP_OUT: begin
            rsp_ff.out_x <= px_ff;
            rsp_ff.out_z <= pz_ff;
            rsp_ff.moved <= moved_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         moved_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            csp_pkg::OP_START: begin
               idx_ff   <= '0;
               moved_ff <= 1'b0;
            end
            csp_pkg::OP_NEXT: idx_ff <= idx_ff + 1'b1;
            csp_pkg::OP_PZ, csp_pkg::OP_NEAR: moved_ff <= 1'b1;
            default: ;
         endcase
         if (cmd.op == csp_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.count_zero = count_in == '0;
   assign stat.last       = CNTW'(idx_ff + 1'b1) == count_in;
   assign stat.long_seg   = len_ff > SW'(csp_pkg::NEAR_ZERO);
   assign stat.contact    = $signed(AW'(dist2_ff)) <= acc_ff;
   assign stat.near       = dist2_ff <= SW'(csp_pkg::NEAR_ZERO);
   assign stat.div_busy   = div_busy;
   assign stat.sqrt_busy  = sqrt_busy;
   assign stat.out_busy   = rsp_valid_ff & rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/csp_ctrl.sv @@
// Sequencer: walks each resolve through the collider steps and drives datapath ops.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_kind,
   input  csp_pkg::stat_type  stat,
   output logic               req_stall,
   output csp_pkg::cmd_type   cmd
);

   localparam logic [5:0] S_IDLE  = 6'd0;
   localparam logic [5:0] S_RD    = 6'd1;
   localparam logic [5:0] S_AB    = 6'd2;
   localparam logic [5:0] S_L0    = 6'd3;
   localparam logic [5:0] S_L1    = 6'd4;
   localparam logic [5:0] S_D0    = 6'd5;
   localparam logic [5:0] S_D1    = 6'd6;
   localparam logic [5:0] S_CLAMP = 6'd7;
   localparam logic [5:0] S_N0X   = 6'd8;
   localparam logic [5:0] S_N1X   = 6'd9;
   localparam logic [5:0] S_DVX   = 6'd10;
   localparam logic [5:0] S_WX    = 6'd11;
   localparam logic [5:0] S_CX    = 6'd12;
   localparam logic [5:0] S_N0Z   = 6'd13;
   localparam logic [5:0] S_N1Z   = 6'd14;
   localparam logic [5:0] S_DVZ   = 6'd15;
   localparam logic [5:0] S_WZ    = 6'd16;
   localparam logic [5:0] S_CZ    = 6'd17;
   localparam logic [5:0] S_DL    = 6'd18;
   localparam logic [5:0] S_E0    = 6'd19;
   localparam logic [5:0] S_E1    = 6'd20;
   localparam logic [5:0] S_MS    = 6'd21;
   localparam logic [5:0] S_MM    = 6'd22;
   localparam logic [5:0] S_CMP   = 6'd23;
   localparam logic [5:0] S_SQ    = 6'd24;
   localparam logic [5:0] S_WS    = 6'd25;
   localparam logic [5:0] S_PUSH  = 6'd26;
   localparam logic [5:0] S_P0X   = 6'd27;
   localparam logic [5:0] S_DPX   = 6'd28;
   localparam logic [5:0] S_WPX   = 6'd29;
   localparam logic [5:0] S_PX    = 6'd30;
   localparam logic [5:0] S_P0Z   = 6'd31;
   localparam logic [5:0] S_DPZ   = 6'd32;
   localparam logic [5:0] S_WPZ   = 6'd33;
   localparam logic [5:0] S_PZ    = 6'd34;
   localparam logic [5:0] S_NEAR  = 6'd35;
   localparam logic [5:0] S_NEXT  = 6'd36;
   localparam logic [5:0] S_FIN   = 6'd37;

   logic [5:0] state_ff;
   logic [5:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = csp_pkg::OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == csp_pkg::KIND_RESOLVE) begin
                  cmd.op   = csp_pkg::OP_START;
                  state_in = stat.count_zero ? S_FIN : S_RD;
               end else begin
                  cmd.op = csp_pkg::OP_WRITE;
               end
            end
         end
         S_RD:    state_in = S_AB;
         S_AB:    begin cmd.op = csp_pkg::OP_AB;  state_in = S_L0; end
         S_L0:    begin cmd.op = csp_pkg::OP_L0;  state_in = S_L1; end
         S_L1:    begin cmd.op = csp_pkg::OP_L1;  state_in = S_D0; end
         S_D0:    begin cmd.op = csp_pkg::OP_D0;  state_in = S_D1; end
         S_D1:    begin cmd.op = csp_pkg::OP_D1;  state_in = S_CLAMP; end
         S_CLAMP: begin
            cmd.op   = csp_pkg::OP_CLAMP;
            state_in = stat.long_seg ? S_N0X : S_DL;
         end
         S_N0X:   begin cmd.op = csp_pkg::OP_N0X;  state_in = S_N1X; end
         S_N1X:   begin cmd.op = csp_pkg::OP_N1X;  state_in = S_DVX; end
         S_DVX:   begin cmd.op = csp_pkg::OP_DIVX; state_in = S_WX; end
         S_WX:    if (!stat.div_busy) state_in = S_CX;
         S_CX:    begin cmd.op = csp_pkg::OP_CX;   state_in = S_N0Z; end
         S_N0Z:   begin cmd.op = csp_pkg::OP_N0Z;  state_in = S_N1Z; end
         S_N1Z:   begin cmd.op = csp_pkg::OP_N1Z;  state_in = S_DVZ; end
         S_DVZ:   begin cmd.op = csp_pkg::OP_DIVZ; state_in = S_WZ; end
         S_WZ:    if (!stat.div_busy) state_in = S_CZ;
         S_CZ:    begin cmd.op = csp_pkg::OP_CZ;   state_in = S_DL; end
         S_DL:    begin cmd.op = csp_pkg::OP_DL;   state_in = S_E0; end
         S_E0:    begin cmd.op = csp_pkg::OP_E0;   state_in = S_E1; end
         S_E1:    begin cmd.op = csp_pkg::OP_E1;   state_in = S_MS; end
         S_MS:    begin cmd.op = csp_pkg::OP_MS;   state_in = S_MM; end
         S_MM:    begin cmd.op = csp_pkg::OP_MM;   state_in = S_CMP; end
         S_CMP: begin
            if (!stat.contact) begin
               state_in = S_NEXT;
            end else if (stat.near) begin
               state_in = S_NEAR;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ:    begin cmd.op = csp_pkg::OP_SQRT;  state_in = S_WS; end
         S_WS:    if (!stat.sqrt_busy) state_in = S_PUSH;
         S_PUSH:  begin cmd.op = csp_pkg::OP_PUSH;  state_in = S_P0X; end
         S_P0X:   begin cmd.op = csp_pkg::OP_P0X;   state_in = S_DPX; end
         S_DPX:   begin cmd.op = csp_pkg::OP_DIVPX; state_in = S_WPX; end
         S_WPX:   if (!stat.div_busy) state_in = S_PX;
         S_PX:    begin cmd.op = csp_pkg::OP_PX;    state_in = S_P0Z; end
         S_P0Z:   begin cmd.op = csp_pkg::OP_P0Z;   state_in = S_DPZ; end
         S_DPZ:   begin cmd.op = csp_pkg::OP_DIVPZ; state_in = S_WPZ; end
         S_WPZ:   if (!stat.div_busy) state_in = S_PZ;
         S_PZ:    begin cmd.op = csp_pkg::OP_PZ;    state_in = S_NEXT; end
         S_NEAR:  begin cmd.op = csp_pkg::OP_NEAR;  state_in = S_NEXT; end
         S_NEXT: begin
            cmd.op   = csp_pkg::OP_NEXT;
            state_in = stat.last ? S_FIN : S_RD;
         end
         S_FIN: begin
            if (!stat.out_busy) begin
               cmd.op   = csp_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule
